// ----- hdl/anbs_pkg.sv -----
// Shared types and constants for the Annex B NAL unit scanner.
package anbs_pkg;

   // Start code lengths in bytes
   localparam logic [2:0] SC_LEN_SHORT = 3'd3;
   localparam logic [2:0] SC_LEN_LONG  = 3'd4;

   // NAL header byte fields
   localparam logic [7:0] HDR_FORBIDDEN_MASK = 8'h80;
   localparam logic [7:0] HDR_REF_IDC_MASK   = 8'h60;
   localparam logic [7:0] HDR_UNIT_TYPE_MASK = 8'h1f;

   // Width of one packed result item, padded to whole bytes
   localparam int RSP_FIELD_BITS = 107;
   localparam int RSP_DATA_BITS  = 112;

   // One result record
   typedef struct packed {
      logic [31:0] payload_length;
      logic [4:0]  unit_type;
      logic [1:0]  ref_idc;
      logic        f_bit;
      logic [2:0]  prefix_length;
      logic [31:0] stream_offset;
      logic [31:0] nal_index;
   } rsp_item_type;

endpackage

// ----- hdl/annexb_nal_unit_scanner_top.sv -----
// Top level of the Annex B NAL unit scanner.
// The scanner takes one stream byte per clock and finds 00 00 01 and
// 00 00 00 01 start codes, the four-byte form winning. For each NAL unit it
// reports its index, the offset of its start code, the prefix length, the
// split header byte and the payload length, when the next start code ends or
// on the byte marked tlast; after tlast all state returns to reset. One item
// is taken every cycle: the start code match, counter updates and record are
// one register-to-register pass, and a two-entry output buffer keeps input
// flowing while a record waits on rsp_tready; req_tready drops only while
// both entries hold records. Counters are COUNT_WIDTH bits and saturate;
// 32-bit result fields clip to all ones.
module annexb_nal_unit_scanner_top #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // end_of_stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] nal_index, [63:32] stream_offset, [66:64] prefix_length,
   // [67] f_bit, [69:68] ref_idc, [74:70] unit_type,
   // [106:75] payload_length, [111:107] zero
   output logic [111:0] rsp_tdata
);
   import anbs_pkg::*;

   localparam int CW = COUNT_WIDTH;
   localparam int EW = (CW > 32) ? CW : 32;

   // Scanner state
   logic [23:0]   recent_ff, recent_in;
   logic          inside_ff, inside_in;
   logic [2:0]    plen_ff, plen_in;
   logic [7:0]    hdr_ff, hdr_in;
   logic          hdr_taken_ff, hdr_taken_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] start_ff, start_in;
   logic [CW-1:0] pstart_ff, pstart_in;
   logic [CW-1:0] count_ff, count_in;

   logic          accept;
   logic          push;
   rsp_item_type  push_item;
   rsp_item_type  rsp_item;
   logic [7:0]    data_byte;
   logic          sc_long, sc_short;
   logic [2:0]    sc_len;
   logic [CW-1:0] next_pos, sc_start, payload;
   logic [7:0]    hdr_sel;

   function automatic logic [31:0] clip32(input logic [CW-1:0] v);
      logic [EW-1:0] ext;
      ext = EW'(v);
      if (ext > EW'(32'hFFFF_FFFF)) begin
         clip32 = 32'hFFFF_FFFF;
      end else begin
         clip32 = ext[31:0];
      end
   endfunction

   function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
      sat_sub = (a > b) ? (a - b) : '0;
   endfunction

   assign accept    = req_tvalid && req_tready;
   assign data_byte = req_tdata[7:0];

   // Start code match on the byte window
   assign sc_long  = (recent_ff == 24'h000000) && (data_byte == 8'h01);
   assign sc_short = (recent_ff[15:0] == 16'h0000) && (data_byte == 8'h01);
   assign sc_len   = sc_long ? SC_LEN_LONG : SC_LEN_SHORT;

   assign next_pos = (pos_ff == {CW{1'b1}}) ? pos_ff : pos_ff + CW'(1);
   assign sc_start = sat_sub(next_pos, CW'(sc_len));

   // Next state and record
   always_comb begin
      recent_in    = {recent_ff[15:0], data_byte};
      inside_in    = inside_ff;
      plen_in      = plen_ff;
      hdr_in       = hdr_ff;
      hdr_taken_in = hdr_taken_ff;
      pos_in       = next_pos;
      start_in     = start_ff;
      pstart_in    = pstart_ff;
      count_in     = count_ff;
      push         = 1'b0;
      payload      = sat_sub(next_pos, pstart_ff);
      hdr_sel      = hdr_ff;
      if (sc_short) begin
         payload = sat_sub(sc_start, pstart_ff);
         if (inside_ff) begin
            push     = 1'b1;
            count_in = (count_ff == {CW{1'b1}}) ? count_ff : count_ff + CW'(1);
         end
         inside_in    = 1'b1;
         plen_in      = sc_len;
         start_in     = sc_start;
         pstart_in    = next_pos;
         hdr_in       = 8'h00;
         hdr_taken_in = 1'b0;
      end else if (inside_ff) begin
         if (!hdr_taken_ff) begin
            hdr_in       = data_byte;
            hdr_taken_in = 1'b1;
            hdr_sel      = data_byte;
         end
         push = req_tlast;
      end
      // End of stream returns everything to reset
      if (req_tlast) begin
         recent_in    = 24'hFFFFFF;
         inside_in    = 1'b0;
         plen_in      = SC_LEN_SHORT;
         hdr_in       = 8'h00;
         hdr_taken_in = 1'b0;
         pos_in       = '0;
         start_in     = '0;
         pstart_in    = '0;
         count_in     = '0;
      end
   end

   // Record fields
   always_comb begin
      push_item.nal_index      = clip32(count_ff);
      push_item.stream_offset  = clip32(start_ff);
      push_item.prefix_length  = plen_ff;
      push_item.f_bit          = |(hdr_sel & HDR_FORBIDDEN_MASK);
      push_item.ref_idc        = 2'((hdr_sel & HDR_REF_IDC_MASK) >> 5);
      push_item.unit_type      = 5'(hdr_sel & HDR_UNIT_TYPE_MASK);
      push_item.payload_length = clip32(payload);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff    <= 24'hFFFFFF;
         inside_ff    <= 1'b0;
         plen_ff      <= SC_LEN_SHORT;
         hdr_ff       <= 8'h00;
         hdr_taken_ff <= 1'b0;
         pos_ff       <= '0;
         start_ff     <= '0;
         pstart_ff    <= '0;
         count_ff     <= '0;
      end else if (accept) begin
         recent_ff    <= recent_in;
         inside_ff    <= inside_in;
         plen_ff      <= plen_in;
         hdr_ff       <= hdr_in;
         hdr_taken_ff <= hdr_taken_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         pstart_ff    <= pstart_in;
         count_ff     <= count_in;
      end
   end

   // Output buffer
   anbs_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && push),
      .push_item  (push_item),
      .push_ready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {(RSP_DATA_BITS - RSP_FIELD_BITS)'(0), rsp_item};

endmodule

// ----- hdl/anbs_skid.sv -----
// Two-entry output buffer that decouples the scanner from the result channel.
module anbs_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  anbs_pkg::rsp_item_type push_item,
   output logic                  push_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output anbs_pkg::rsp_item_type rsp_item
);
   import anbs_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_item_ff, main_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         main_free;

   // A new item is taken only while the skid entry is empty
   assign push_ready = !skid_valid_ff;
   assign main_free  = !main_valid_ff || rsp_tready;

   // Entry steering
   always_comb begin
      main_valid_in = main_valid_ff;
      main_item_in  = main_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_item_in  = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_item_in  = push_item;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_item_in  = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_item_ff <= main_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_item   = main_item_ff;

endmodule
